/* rtl/lmdr_pkg.sv */
// Shared widths, function codes and driver register codes for the LED matrix refresh block.
package lmdr_pkg;

    localparam int ROWS     = 8;
    localparam int ROW_W    = 3;
    localparam int PANEL_W  = 3;
    localparam int VALUE_W  = 8;
    localparam int FUNC_W   = 2;
    localparam int WORD_W   = 16;
    localparam int BRIGHT_W = 4;

    typedef logic [FUNC_W-1:0]   func_t;
    typedef logic [ROW_W-1:0]    row_t;
    typedef logic [PANEL_W-1:0]  panel_t;
    typedef logic [VALUE_W-1:0]  value_t;
    typedef logic [WORD_W-1:0]   word_t;
    typedef logic [BRIGHT_W-1:0] bright_t;

    // request function codes
    localparam func_t FUNC_WRITE    = 2'd0;
    localparam func_t FUNC_REFRESH  = 2'd1;
    localparam func_t FUNC_POWER    = 2'd2;
    localparam func_t FUNC_SETTINGS = 2'd3;

    // driver register map
    localparam logic [7:0] REG_DIGIT0    = 8'h01;
    localparam logic [7:0] REG_DECODE    = 8'h09;
    localparam logic [7:0] REG_INTENSITY = 8'h0A;
    localparam logic [7:0] REG_SCANLIMIT = 8'h0B;
    localparam logic [7:0] REG_SHUTDOWN  = 8'h0C;
    localparam logic [7:0] REG_TEST      = 8'h0F;
    localparam logic [7:0] SCAN_ALL_ROWS = 8'h07;

    // settings sequence frame order
    localparam logic [1:0] SET_TEST      = 2'd0;
    localparam logic [1:0] SET_DECODE    = 2'd1;
    localparam logic [1:0] SET_INTENSITY = 2'd2;
    localparam logic [1:0] SET_SCANLIMIT = 2'd3;

    function automatic word_t settings_word(input logic [1:0] fidx, input bright_t bright);
        word_t w;
        case (fidx)
            SET_TEST:      w = {REG_TEST, 8'h00};
            SET_DECODE:    w = {REG_DECODE, 8'h00};
            SET_INTENSITY: w = {REG_INTENSITY, 4'h0, bright};
            default:       w = {REG_SCANLIMIT, SCAN_ALL_ROWS};
        endcase
        return w;
    endfunction

endpackage

/* rtl/lmdr_if.sv */
// Valid/ready channel interfaces: request, result and configuration write.
interface lmdr_req_if import lmdr_pkg::*; ();
    logic   valid;
    logic   ready;
    func_t  func;
    row_t   row;
    panel_t panel;
    value_t value;

    modport source (output valid, output func, output row, output panel, output value,
                    input ready);
    modport sink   (input valid, input func, input row, input panel, input value,
                    output ready);
endinterface

interface lmdr_res_if import lmdr_pkg::*; ();
    logic  valid;
    logic  ready;
    word_t word;
    logic  frame_end;
    logic  last;

    modport source (output valid, output word, output frame_end, output last, input ready);
    modport sink   (input valid, input word, input frame_end, input last, output ready);
endinterface

interface lmdr_cfg_if import lmdr_pkg::*; ();
    logic    valid;
    logic    ready;
    bright_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/led_matrix_dirty_row_refresh.sv */
// Dirty-row framebuffer refresh for a chain of LED matrix drivers (top level).
// Segment write: read, then compare and write back on a change; no result.
// Refresh (up to 8*PANELS words): rows examined in turn; each word read, then output.
// Power: PANELS words, settings: 4*PANELS words, one per cycle while results are taken.
// One request is worked at a time; results wait in a single output register.
// Reset: frame store reads as zero with every mark set through per-entry valid flops.
module led_matrix_dirty_row_refresh
    import lmdr_pkg::*;
#(
    parameter int PANELS = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    lmdr_req_if.sink     req,
    lmdr_res_if.source   res,
    lmdr_cfg_if.sink     cfg
);

    localparam int CELLS = ROWS * PANELS;
    localparam int AW    = $clog2(CELLS);
    localparam int PW    = (PANELS > 1) ? $clog2(PANELS) : 1;
    localparam int CW    = (PW > PANEL_W) ? PW : PANEL_W;
    localparam int DW    = VALUE_W + 1;     // {dirty, data}

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_WR_CMP  = 3'd1;
    localparam logic [2:0] S_REF_ROW = 3'd2;
    localparam logic [2:0] S_REF_RD  = 3'd3;
    localparam logic [2:0] S_REF_OUT = 3'd4;
    localparam logic [2:0] S_BCAST   = 3'd5;

    // framebuffer memory: one entry per (row, panel), holding mark and byte
    logic [DW-1:0] mem [CELLS];
    logic [DW-1:0] rdata_reg;
    logic          rvalid_reg;

    // entries never written read as byte zero with mark set
    logic [CELLS-1:0] valid_reg, valid_next;
    // a row flag is set when any panel of that row is marked dirty
    logic [ROWS-1:0]  row_dirty_reg, row_dirty_next;

    logic [2:0]    state_reg, state_next;
    logic          on_reg, on_next;
    bright_t       bright_reg, bright_next;
    row_t          row_reg, row_next;
    panel_t        panel_reg, panel_next;
    value_t        value_reg, value_next;
    row_t          rcnt_reg, rcnt_next;
    logic [PW-1:0] pcnt_reg, pcnt_next;
    logic [1:0]    fcnt_reg, fcnt_next;
    logic          bc_set_reg, bc_set_next;

    logic          res_valid_reg, res_valid_next;
    word_t         word_reg, word_next;
    logic          frame_end_reg, frame_end_next;
    logic          last_reg, last_next;

    // memory access controls
    logic          mem_we;
    logic          mem_re;
    logic [DW-1:0] mem_wdata;
    row_t          addr_row;
    logic [CW-1:0] addr_col;
    logic [AW-1:0] addr;

    logic          out_free;
    logic          pcnt_last;
    logic          cur_dirty;
    value_t        cur_data;
    logic          later_dirty;

    assign addr = AW'(addr_row) * AW'(PANELS) + AW'(addr_col);

    assign req.ready     = (state_reg == S_IDLE);
    assign cfg.ready     = 1'b1;
    assign res.valid     = res_valid_reg;
    assign res.word      = word_reg;
    assign res.frame_end = frame_end_reg;
    assign res.last      = last_reg;

    // output register can take a word when empty or being drained this cycle
    assign out_free  = !res_valid_reg || res.ready;
    assign pcnt_last = (pcnt_reg == PW'(PANELS - 1));
    assign cur_dirty = rvalid_reg ? rdata_reg[VALUE_W] : 1'b1;
    assign cur_data  = rvalid_reg ? rdata_reg[VALUE_W-1:0] : '0;

    // any dirty row after the one being sent decides the request's last word
    always_comb
    begin
        later_dirty = 1'b0;
        for (int r = 0; r < ROWS; r++)
        begin
            if ((ROW_W'(r) > rcnt_reg) && row_dirty_reg[r])
            begin
                later_dirty = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        on_next        = on_reg;
        bright_next    = cfg.valid ? cfg.data : bright_reg;
        row_next       = row_reg;
        panel_next     = panel_reg;
        value_next     = value_reg;
        rcnt_next      = rcnt_reg;
        pcnt_next      = pcnt_reg;
        fcnt_next      = fcnt_reg;
        bc_set_next    = bc_set_reg;
        valid_next     = valid_reg;
        row_dirty_next = row_dirty_reg;
        res_valid_next = res_valid_reg && !res.ready;
        word_next      = word_reg;
        frame_end_next = frame_end_reg;
        last_next      = last_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_wdata      = '0;
        addr_row       = rcnt_reg;
        addr_col       = CW'(pcnt_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    row_next   = req.row;
                    panel_next = req.panel;
                    value_next = req.value;
                    case (req.func)
                        FUNC_WRITE:
                        begin
                            // panels beyond the chain are dropped
                            if (int'(req.panel) < PANELS)
                            begin
                                addr_row   = req.row;
                                addr_col   = CW'(req.panel);
                                mem_re     = 1'b1;
                                state_next = S_WR_CMP;
                            end
                        end
                        FUNC_REFRESH:
                        begin
                            if (on_reg)
                            begin
                                rcnt_next  = '0;
                                state_next = S_REF_ROW;
                            end
                        end
                        FUNC_POWER:
                        begin
                            // shutdown frame only on a change of power state
                            if (req.value[0] != on_reg)
                            begin
                                on_next     = req.value[0];
                                bc_set_next = 1'b0;
                                pcnt_next   = '0;
                                fcnt_next   = '0;
                                state_next  = S_BCAST;
                            end
                        end
                        default:
                        begin
                            bc_set_next = 1'b1;
                            pcnt_next   = '0;
                            fcnt_next   = SET_TEST;
                            state_next  = S_BCAST;
                        end
                    endcase
                end
            end

            S_WR_CMP:
            begin
                // stored byte is back; write and mark only on a change
                addr_row = row_reg;
                addr_col = CW'(panel_reg);
                if (cur_data != value_reg)
                begin
                    mem_we                  = 1'b1;
                    mem_wdata               = {1'b1, value_reg};
                    valid_next[addr]        = 1'b1;
                    row_dirty_next[row_reg] = 1'b1;
                end
                state_next = S_IDLE;
            end

            S_REF_ROW:
            begin
                if (row_dirty_reg[rcnt_reg])
                begin
                    pcnt_next  = '0;
                    state_next = S_REF_RD;
                end
                else if (rcnt_reg == ROW_W'(ROWS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    rcnt_next = rcnt_reg + 1'b1;
                end
            end

            S_REF_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_REF_OUT;
            end

            S_REF_OUT:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    word_next      = cur_dirty ? {REG_DIGIT0 + 8'(rcnt_reg), cur_data} : '0;
                    frame_end_next = pcnt_last;
                    last_next      = pcnt_last && !later_dirty;
                    // clear the mark of a sent panel
                    if (cur_dirty)
                    begin
                        mem_we           = 1'b1;
                        mem_wdata        = {1'b0, cur_data};
                        valid_next[addr] = 1'b1;
                    end
                    if (pcnt_last)
                    begin
                        row_dirty_next[rcnt_reg] = 1'b0;
                        if (later_dirty)
                        begin
                            rcnt_next  = rcnt_reg + 1'b1;
                            state_next = S_REF_ROW;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        pcnt_next  = pcnt_reg + 1'b1;
                        state_next = S_REF_RD;
                    end
                end
            end

            S_BCAST:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    word_next      = bc_set_reg ? settings_word(fcnt_reg, bright_reg)
                                                : {REG_SHUTDOWN, 7'b0, on_reg};
                    frame_end_next = pcnt_last;
                    last_next      = pcnt_last && (!bc_set_reg || fcnt_reg == SET_SCANLIMIT);
                    if (pcnt_last)
                    begin
                        pcnt_next = '0;
                        if (!bc_set_reg || fcnt_reg == SET_SCANLIMIT)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            fcnt_next = fcnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        pcnt_next = pcnt_reg + 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            on_reg        <= 1'b0;
            bright_reg    <= 4'd7;
            valid_reg     <= '0;
            row_dirty_reg <= '1;
            res_valid_reg <= 1'b0;
            rcnt_reg      <= '0;
            pcnt_reg      <= '0;
            fcnt_reg      <= '0;
            bc_set_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            on_reg        <= on_next;
            bright_reg    <= bright_next;
            valid_reg     <= valid_next;
            row_dirty_reg <= row_dirty_next;
            res_valid_reg <= res_valid_next;
            rcnt_reg      <= rcnt_next;
            pcnt_reg      <= pcnt_next;
            fcnt_reg      <= fcnt_next;
            bc_set_reg    <= bc_set_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        row_reg       <= row_next;
        panel_reg     <= panel_next;
        value_reg     <= value_next;
        word_reg      <= word_next;
        frame_end_reg <= frame_end_next;
        last_reg      <= last_next;
    end

    // single-port framebuffer, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg  <= mem[addr];
            rvalid_reg <= valid_reg[addr];
        end
    end

endmodule

/* bench/testbench.sv */
// Testbench for the LED matrix dirty-row refresh block: scoreboard class plus request drivers.
`timescale 1ns / 1ps

module testbench import lmdr_pkg::*; ();

    localparam int NPANELS   = 8;                  // chain length the block is built with
    localparam int CELLS     = ROWS * NPANELS;
    localparam int SETTLE    = 16;                 // cycles covering a silent request (write, idle refresh)
    localparam int TAIL      = 32;                 // quiet cycles after the last result
    localparam int LIMIT     = 4_000_000;          // watchdog, in clock cycles
    localparam int PHASES    = 5;
    localparam int PHASE_LEN = 60;

    // One expected command word on the result channel.
    typedef struct {
        word_t word;
        logic  frame_end;
        logic  last;
    } cmd_word_t;

    // Scoreboard: holds its own framebuffer, dirty marks, power state and brightness,
    // and turns each accepted request into the command words the chain should see.
    class refresh_scoreboard;
        value_t    pixels[CELLS];
        bit        dirty[CELLS];
        bit        lit;
        bright_t   bright;
        cmd_word_t pending[$];
        int        errors;

        function new();
            foreach (pixels[i])
            begin
                pixels[i] = '0;
                dirty[i]  = 1'b1;    // every entry starts dirty: first refresh sends all
            end
            lit    = 1'b0;
            bright = 4'd7;
            errors = 0;
        endfunction

        function void set_brightness(bright_t b);
            bright = b;
        endfunction

        function void push_word(word_t w, bit fe);
            pending.push_back('{word: w, frame_end: fe, last: 1'b0});
        endfunction

        // Same word to every panel, one frame.
        function void push_broadcast(logic [7:0] addr, logic [7:0] data);
            for (int pn = 0; pn < NPANELS; pn++)
                push_word({addr, data}, pn == NPANELS - 1);
        endfunction

        function void note_request(func_t f, row_t r, panel_t p, value_t v);
            int         base;
            int         pos;
            bit         any;
            logic [7:0] addr;
            base = pending.size();
            case (f)
                FUNC_WRITE:
                begin
                    // only a changed byte gets marked
                    if (int'(p) < NPANELS)
                    begin
                        pos = int'(r) * NPANELS + int'(p);
                        if (pixels[pos] != v)
                        begin
                            pixels[pos] = v;
                            dirty[pos]  = 1'b1;
                        end
                    end
                end
                FUNC_REFRESH:
                begin
                    if (lit)
                    begin
                        for (int rw = 0; rw < ROWS; rw++)
                        begin
                            any = 1'b0;
                            for (int pn = 0; pn < NPANELS; pn++)
                                if (dirty[rw * NPANELS + pn])
                                    any = 1'b1;
                            if (any)
                            begin
                                addr = REG_DIGIT0 + 8'(rw);
                                for (int pn = 0; pn < NPANELS; pn++)
                                begin
                                    pos = rw * NPANELS + pn;
                                    if (dirty[pos])
                                    begin
                                        push_word({addr, pixels[pos]}, pn == NPANELS - 1);
                                        dirty[pos] = 1'b0;
                                    end
                                    else
                                        push_word('0, pn == NPANELS - 1);   // no-op to a clean panel
                                end
                            end
                        end
                    end
                end
                FUNC_POWER:
                begin
                    if (v[0] != lit)
                    begin
                        push_broadcast(REG_SHUTDOWN, {7'b0, v[0]});
                        lit = v[0];
                    end
                end
                default:
                begin
                    push_broadcast(REG_TEST, 8'h00);
                    push_broadcast(REG_DECODE, 8'h00);
                    push_broadcast(REG_INTENSITY, {4'h0, bright});
                    push_broadcast(REG_SCANLIMIT, SCAN_ALL_ROWS);
                end
            endcase
            if (pending.size() > base)
                pending[pending.size() - 1].last = 1'b1;
        endfunction

        function void check_result(word_t w, logic fe, logic l);
            cmd_word_t exp_word;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word=%h frame_end=%b last=%b", $time, w, fe, l);
                return;
            end
            exp_word = pending.pop_front();
            if (exp_word.word !== w)
            begin
                errors++;
                $display("%0t: word expected %h actual %h", $time, exp_word.word, w);
            end
            if (exp_word.frame_end !== fe)
            begin
                errors++;
                $display("%0t: frame_end expected %b actual %b (word %h)",
                         $time, exp_word.frame_end, fe, exp_word.word);
            end
            if (exp_word.last !== l)
            begin
                errors++;
                $display("%0t: last expected %b actual %b (word %h)",
                         $time, exp_word.last, l, exp_word.word);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   calm;          // when set, neither side idles: back-to-back traffic
    int   cycles = 0;
    int   stall_left = 0;

    refresh_scoreboard sb = new();

    lmdr_req_if req_if();
    lmdr_res_if res_if();
    lmdr_cfg_if cfg_if();

    led_matrix_dirty_row_refresh #(.PANELS(NPANELS)) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .res   (res_if),
        .cfg   (cfg_if)
    );

    // 4 ns clock
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog. Worst case is ~330 requests each emitting 64 words, every word
    // held up by the longest result stall, and LIMIT is several times over that.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: back-pressure with mostly short stalls and the odd long one.
    always @(posedge clk)
    begin : result_ready
        int pick;
        if (!rst_n)
            res_if.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left    <= stall_left - 1;
            res_if.ready  <= 1'b0;
        end
        else if (calm)
            res_if.ready <= 1'b1;
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                res_if.ready <= 1'b1;
            else if (pick < 95)
            begin
                res_if.ready <= 1'b0;
                stall_left   <= $urandom_range(0, 2);
            end
            else
            begin
                res_if.ready <= 1'b0;
                stall_left   <= $urandom_range(5, 30);
            end
        end
    end

    // Result monitor: every accepted word is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            sb.check_result(res_if.word, res_if.frame_end, res_if.last);
    end

    // Idle gap before a request: mostly none, some short, a few long.
    function automatic int pick_gap();
        int pick;
        if (calm)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    // Present one request and hold it until the block takes it. Valid is left
    // high after acceptance so back-to-back requests never toggle it in one step.
    task automatic send_request(func_t f, row_t r, panel_t p, value_t v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.func  <= f;
        req_if.row   <= r;
        req_if.panel <= p;
        req_if.value <= v;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        sb.note_request(f, r, p, v);
    endtask

    // Wait for every expected word, then give a silent request time to finish.
    task automatic drain();
        req_if.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_brightness(bright_t b);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= b;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
        sb.set_brightness(b);
    endtask

    // Mostly segment writes (a quarter rewriting the stored byte), then refreshes,
    // power changes biased toward on so refreshes have something to send, and settings.
    task automatic random_phase(int count);
        int     pick;
        row_t   r;
        panel_t p;
        value_t v;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 19) == 0)
                calm = ~calm;
            pick = $urandom_range(0, 99);
            r    = row_t'($urandom_range(0, 7));
            p    = panel_t'($urandom_range(0, 7));
            v    = value_t'($urandom_range(0, 255));
            if (pick < 60)
            begin
                case ($urandom_range(0, 3))
                    0:       v = sb.pixels[int'(r) * NPANELS + int'(p)];
                    1:       v = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
                    default: ;
                endcase
                send_request(FUNC_WRITE, r, p, v);
            end
            else if (pick < 80)
                send_request(FUNC_REFRESH, r, p, v);
            else if (pick < 92)
            begin
                v[0] = ($urandom_range(0, 9) < 7);
                send_request(FUNC_POWER, r, p, v);
            end
            else
                send_request(FUNC_SETTINGS, r, p, v);
        end
    endtask

    initial
    begin : stimulus
        rst_n         = 1'b0;
        calm          = 1'b0;
        req_if.valid  = 1'b0;
        req_if.func   = FUNC_WRITE;
        req_if.row    = '0;
        req_if.panel  = '0;
        req_if.value  = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.data   = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed ---
        send_request(FUNC_REFRESH, 3'd0, 3'd0, 8'h00);    // panels off: silent
        send_request(FUNC_POWER, 3'd0, 3'd0, 8'h00);      // already off: silent
        send_request(FUNC_SETTINGS, 3'd0, 3'd0, 8'h00);   // brightness at reset value
        send_request(FUNC_POWER, 3'd0, 3'd0, 8'h01);      // power on
        send_request(FUNC_POWER, 3'd7, 3'd7, 8'h03);      // already on: silent
        send_request(FUNC_REFRESH, 3'd0, 3'd0, 8'h00);    // all entries dirty from reset
        send_request(FUNC_REFRESH, 3'd0, 3'd0, 8'h00);    // nothing dirty
        send_request(FUNC_WRITE, 3'd0, 3'd0, 8'hFF);
        send_request(FUNC_WRITE, 3'd7, 3'd7, 8'h80);
        send_request(FUNC_WRITE, 3'd3, 3'd5, 8'h01);
        send_request(FUNC_WRITE, 3'd3, 3'd5, 8'h01);      // same byte again
        send_request(FUNC_WRITE, 3'd2, 3'd2, 8'h00);      // matches store: stays clean
        send_request(FUNC_REFRESH, 3'd0, 3'd0, 8'h00);    // rows 0, 3, 7 with no-op fill
        send_request(FUNC_WRITE, 3'd0, 3'd0, 8'hFF);      // unchanged after refresh
        send_request(FUNC_REFRESH, 3'd0, 3'd0, 8'h00);    // silent
        send_request(FUNC_WRITE, 3'd4, 3'd1, 8'hAA);
        send_request(FUNC_POWER, 3'd0, 3'd0, 8'hFE);      // bit 0 clear: off
        send_request(FUNC_REFRESH, 3'd0, 3'd0, 8'h00);    // off: marks survive
        send_request(FUNC_WRITE, 3'd4, 3'd6, 8'h55);
        send_request(FUNC_POWER, 3'd0, 3'd0, 8'hFF);      // on, upper bits ignored
        send_request(FUNC_REFRESH, 3'd0, 3'd0, 8'h00);    // row 4, two panels dirty
        drain();
        write_brightness(4'd0);
        send_request(FUNC_SETTINGS, 3'd0, 3'd0, 8'h00);
        drain();
        write_brightness(4'd15);
        send_request(FUNC_SETTINGS, 3'd0, 3'd0, 8'h00);

        // --- random, one brightness setting per phase ---
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            case (ph)
                1:       write_brightness(4'd0);
                2:       write_brightness(4'd15);
                default: write_brightness(bright_t'($urandom_range(1, 14)));
            endcase
            calm = ($urandom_range(0, 3) == 0);
            random_phase(PHASE_LEN);
        end

        drain();
        repeat (TAIL) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
